FILE: rtl/sab_pkg.sv
`timescale 1ns / 1ps
package sab_pkg;
  localparam int MAX_LEN    = 1024;
  localparam int MAX_STATES = 2048;
  localparam int ALPHABET   = 26;

  localparam int STATE_W = 11;
  localparam int CNT_W   = 12;
  localparam int SYM_W   = 5;
  localparam int LEN_W   = 11;
  localparam int TOT_W   = 20;
  localparam int EDGE_AW = STATE_W + SYM_W;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 64;

  localparam logic       ACT_APPEND = 1'b0;
  localparam logic       ACT_READ   = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOSTATE = 2'd2;

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_RD   = 14'b00000000000100,
    S_LAST = 14'b00000000001000,
    S_W1   = 14'b00000000010000,
    S_W1L  = 14'b00000000100000,
    S_P2   = 14'b00000001000000,
    S_P3   = 14'b00000010000000,
    S_CL   = 14'b00000100000000,
    S_CQ   = 14'b00001000000000,
    S_CP   = 14'b00010000000000,
    S_R    = 14'b00100000000000,
    S_RL   = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } seq_e;
endpackage

FILE: rtl/suffix_automaton_builder_unit.sv
`timescale 1ns / 1ps
// Sequence: a read looks up its memories, then answers; a refused append answers from idle.
// An append walks the suffix links from the last state until the root or an existing
// transition is met; when a clone is made, it copies the transitions and redirects the chain.
// Throughput: one transaction in flight; the next is accepted as the result is taken.
// Reset: async active low; a pass over all edge addresses then clears the edge, length and link
// memories with s_axis_tready_o low.
module suffix_automaton_builder_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // action[0]
  input  logic                    s_axis_tuser_i,
  // symbol[4:0], state_index[15:5]
  input  logic [sab_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // status[1:0], node[12:2], found[13], node_length[24:14], node_link[35:25],
  // has_link[36], cloned[37], distinct_count[57:38]
  output logic [sab_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import sab_pkg::*;

  logic [STATE_W-1:0] edge_mem [2**EDGE_AW];
  logic [LEN_W-1:0]   len_mem  [2**STATE_W];
  logic [STATE_W-1:0] link_mem [2**STATE_W];

  logic               e_we, l_we, k_we;
  logic [EDGE_AW-1:0] e_wa, e_ra;
  logic [STATE_W-1:0] e_wd, l_wa, l_ra, k_wa, k_ra, k_wd;
  logic [LEN_W-1:0]   l_wd;
  logic [STATE_W-1:0] e_rd_q, k_rd_q;
  logic [LEN_W-1:0]   l_rd_q;

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    e_rd_q <= edge_mem[e_ra];
  end
  always_ff @(posedge clk_i) begin
    if (l_we) len_mem[l_wa] <= l_wd;
    l_rd_q <= len_mem[l_ra];
  end
  always_ff @(posedge clk_i) begin
    if (k_we) link_mem[k_wa] <= k_wd;
    k_rd_q <= link_mem[k_ra];
  end

  seq_e               state_q, state_d;
  logic [EDGE_AW-1:0] clr_q, clr_d;
  logic [SYM_W-1:0]   sym_q, sym_d, k_q, k_d;
  logic [STATE_W-1:0] idx_q, idx_d, fresh_q, fresh_d, cur_q, cur_d, qs_q, qs_d;
  logic [STATE_W-1:0] cl_q, cl_d, lnk_q, lnk_d, last_q, last_d;
  logic [LEN_W-1:0]   lc_q, lc_d, lfr_q, lfr_d, lnkl_q, lnkl_d;
  logic               cloned_q, cloned_d, ovld_q, ovld_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   chars_q, chars_d;
  logic [TOT_W-1:0]   tot_q, tot_d;
  logic [OUT_W-1:0]   out_q, out_d;

  logic               acc;
  logic               in_act;
  logic [SYM_W-1:0]   in_sym;
  logic [STATE_W-1:0] in_idx, tgt;
  logic [LEN_W-1:0]   lc1;

  assign in_act = s_axis_tuser_i;
  assign in_sym = s_axis_tdata_i[4:0];
  assign in_idx = s_axis_tdata_i[15:5];
  assign s_axis_tready_o = (state_q == S_IDLE) && (!ovld_q || m_axis_tready_i);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o = out_q;
  assign lc1 = lc_q + LEN_W'(1);
  assign tgt = (sym_q < SYM_W'(ALPHABET)) ? e_rd_q : '0;

  function automatic logic [OUT_W-1:0] pack(
    input logic [1:0] st, input logic [STATE_W-1:0] nd, input logic fd,
    input logic [LEN_W-1:0] ln, input logic [STATE_W-1:0] lk, input logic hl,
    input logic cln, input logic [TOT_W-1:0] tt);
    pack = {6'd0, tt, cln, hl, lk, ln, fd, nd, st};
  endfunction

  always_comb begin
    state_d = state_q; clr_d = clr_q; sym_d = sym_q; k_d = k_q; idx_d = idx_q;
    fresh_d = fresh_q; cur_d = cur_q; qs_d = qs_q; cl_d = cl_q; lnk_d = lnk_q;
    last_d = last_q; lc_d = lc_q; lfr_d = lfr_q; lnkl_d = lnkl_q;
    cloned_d = cloned_q; cnt_d = cnt_q; chars_d = chars_q; tot_d = tot_q;
    out_d = out_q;
    ovld_d = ovld_q && !m_axis_tready_i;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
    unique case (state_q)
      S_CLR: begin
        e_we = 1'b1; e_wa = clr_q;
        l_we = 1'b1; l_wa = clr_q[STATE_W-1:0];
        k_we = 1'b1; k_wa = clr_q[STATE_W-1:0];
        clr_d = clr_q + EDGE_AW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          sym_d = in_sym; idx_d = in_idx; cloned_d = 1'b0;
          if (in_act == ACT_READ) begin
            if ({1'b0, in_idx} >= cnt_q) begin
              out_d = pack(ST_NOSTATE, '0, 1'b0, '0, '0, 1'b0, 1'b0, tot_q);
              ovld_d = 1'b1;
            end else begin
              e_ra = {in_idx, in_sym}; l_ra = in_idx; k_ra = in_idx;
              state_d = S_RD;
            end
          end else if (in_sym >= SYM_W'(ALPHABET) || chars_q >= LEN_W'(MAX_LEN) ||
                       ({1'b0, cnt_q} + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_STATES)) begin
            out_d = pack(ST_FULL, '0, 1'b0, '0, '0, 1'b0, 1'b0, tot_q);
            ovld_d = 1'b1;
          end else begin
            fresh_d = cnt_q[STATE_W-1:0];
            l_ra = last_q; k_ra = last_q;
            state_d = S_LAST;
          end
        end
      end
      S_RD: begin
        out_d = pack(ST_OK, tgt, tgt != '0, l_rd_q, k_rd_q, idx_q != '0, 1'b0, tot_q);
        ovld_d = 1'b1;
        state_d = S_IDLE;
      end
      S_LAST: begin
        lfr_d = l_rd_q + LEN_W'(1);
        l_we = 1'b1; l_wa = fresh_q; l_wd = l_rd_q + LEN_W'(1);
        e_we = 1'b1; e_wa = {last_q, sym_q}; e_wd = fresh_q;
        cnt_d = cnt_q + CNT_W'(1); chars_d = chars_q + LEN_W'(1);
        last_d = fresh_q; lnk_d = '0; lnkl_d = '0;
        if (last_q == '0) begin
          state_d = S_FIN;
        end else begin
          cur_d = k_rd_q; e_ra = {k_rd_q, sym_q};
          state_d = S_W1;
        end
      end
      S_W1: begin
        if (e_rd_q != '0) begin
          qs_d = e_rd_q; l_ra = cur_q;
          state_d = S_P2;
        end else begin
          e_we = 1'b1; e_wa = {cur_q, sym_q}; e_wd = fresh_q;
          if (cur_q == '0) begin
            state_d = S_FIN;
          end else begin
            k_ra = cur_q;
            state_d = S_W1L;
          end
        end
      end
      S_W1L: begin
        cur_d = k_rd_q; e_ra = {k_rd_q, sym_q};
        state_d = S_W1;
      end
      S_P2: begin
        lc_d = l_rd_q; l_ra = qs_q;
        state_d = S_P3;
      end
      S_P3: begin
        if (lc1 == l_rd_q) begin
          lnk_d = qs_q; lnkl_d = l_rd_q;
          state_d = S_FIN;
        end else begin
          cl_d = cnt_q[STATE_W-1:0]; cnt_d = cnt_q + CNT_W'(1); cloned_d = 1'b1;
          l_we = 1'b1; l_wa = cnt_q[STATE_W-1:0]; l_wd = lc1;
          k_ra = qs_q;
          state_d = S_CL;
        end
      end
      S_CL: begin
        k_we = 1'b1; k_wa = cl_q; k_wd = k_rd_q;
        state_d = S_CQ;
      end
      S_CQ: begin
        k_we = 1'b1; k_wa = qs_q; k_wd = cl_q;
        lnk_d = cl_q; lnkl_d = lc1; k_d = '0;
        state_d = S_CP;
      end
      S_CP: begin
        if (k_q < SYM_W'(ALPHABET)) e_ra = {qs_q, k_q};
        if (k_q != '0) begin
          e_we = 1'b1; e_wa = {cl_q, k_q - SYM_W'(1)}; e_wd = e_rd_q;
        end
        k_d = k_q + SYM_W'(1);
        if (k_q == SYM_W'(ALPHABET)) begin
          e_ra = {cur_q, sym_q};
          state_d = S_R;
        end
      end
      S_R: begin
        if (e_rd_q != qs_q) begin
          state_d = S_FIN;
        end else begin
          e_we = 1'b1; e_wa = {cur_q, sym_q}; e_wd = cl_q;
          if (cur_q == '0) begin
            state_d = S_FIN;
          end else begin
            k_ra = cur_q;
            state_d = S_RL;
          end
        end
      end
      S_RL: begin
        cur_d = k_rd_q; e_ra = {k_rd_q, sym_q};
        state_d = S_R;
      end
      S_FIN: begin
        k_we = 1'b1; k_wa = fresh_q; k_wd = lnk_q;
        tot_d = tot_q + TOT_W'(lfr_q - lnkl_q);
        out_d = pack(ST_OK, fresh_q, 1'b1, lfr_q, lnk_q, 1'b1, cloned_q,
                     tot_q + TOT_W'(lfr_q - lnkl_q));
        ovld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ovld_q  <= 1'b0;
      last_q  <= '0;
      cnt_q   <= CNT_W'(1);
      chars_q <= '0;
      tot_q   <= TOT_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ovld_q  <= ovld_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      chars_q <= chars_d;
      tot_q   <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; k_q <= k_d; idx_q <= idx_d; fresh_q <= fresh_d; cur_q <= cur_d;
    qs_q <= qs_d; cl_q <= cl_d; lnk_q <= lnk_d; lc_q <= lc_d; lfr_q <= lfr_d;
    lnkl_q <= lnkl_d; cloned_q <= cloned_d; out_q <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_STATES)) else $error("state count overflow");
  a_chars_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= LEN_W'(MAX_LEN)) else $error("stored length overflow");
  a_clone_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q[37]) |-> (out_q[1:0] == ST_OK))
    else $error("clone flag on failed transaction");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
endmodule

FILE: dv/sab_checker.sv
`timescale 1ns / 1ps
module sab_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic                      s_ready_i,
  input  logic                      s_user_i,
  input  logic [sab_pkg::IN_W-1:0]  s_data_i,
  input  logic                      m_valid_i,
  input  logic                      m_ready_i,
  input  logic [sab_pkg::OUT_W-1:0] m_data_i,
  output int                        errors_o,
  output int                        pending_o
);
  import sab_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] node;
    logic        found;
    logic [10:0] len;
    logic [10:0] link;
    logic        has_link;
    logic        cloned;
    logic [19:0] total;
  } reply_t;

  logic [10:0] edges [MAX_STATES*ALPHABET];
  logic [10:0] lens  [MAX_STATES];
  logic [10:0] links [MAX_STATES];
  int          last_st = 0;
  int          n_states = 1;
  int          n_chars = 0;
  int          n_errors = 0;
  logic [19:0] total = 20'd1;
  reply_t      replies_q [$];

  function automatic int eix(int s, int c);
    return s * ALPHABET + c;
  endfunction

  function automatic reply_t automaton_step(logic act, int sym, int idx);
    reply_t r;
    int fresh, cur, q, cl;
    bit walking;
    r = '0;
    if (act == ACT_READ) begin
      if (idx >= n_states) begin
        r.status = ST_NOSTATE;
      end else begin
        r.status = ST_OK;
        if (sym < ALPHABET) r.node = edges[eix(idx, sym)];
        r.found = r.node != 0;
        r.len = lens[idx];
        r.link = links[idx];
        r.has_link = idx != 0;
      end
      r.total = total;
      return r;
    end
    if (sym >= ALPHABET || n_chars >= MAX_LEN || n_states + 2 > MAX_STATES) begin
      r.status = ST_FULL;
      r.total = total;
      return r;
    end
    fresh = n_states;
    cur = 0;
    walking = last_st != 0;
    n_states++;
    n_chars++;
    lens[fresh] = lens[last_st] + 1;
    links[fresh] = 0;
    edges[eix(last_st, sym)] = fresh;
    if (walking) cur = links[last_st];
    last_st = fresh;
    while (walking && edges[eix(cur, sym)] == 0) begin
      edges[eix(cur, sym)] = fresh;
      if (cur == 0) walking = 0;
      else cur = links[cur];
    end
    if (walking) begin
      q = edges[eix(cur, sym)];
      if (lens[cur] + 11'd1 == lens[q]) begin
        links[fresh] = q;
      end else begin
        cl = n_states;
        n_states++;
        r.cloned = 1;
        lens[cl] = lens[cur] + 1;
        links[cl] = links[q];
        for (int c = 0; c < ALPHABET; c++) edges[eix(cl, c)] = edges[eix(q, c)];
        links[fresh] = cl;
        links[q] = cl;
        while (walking && edges[eix(cur, sym)] == q) begin
          edges[eix(cur, sym)] = cl;
          if (cur == 0) walking = 0;
          else cur = links[cur];
        end
      end
    end
    total = total + lens[fresh] - lens[links[fresh]];
    r.status = ST_OK;
    r.node = fresh;
    r.found = 1;
    r.len = lens[fresh];
    r.link = links[fresh];
    r.has_link = 1;
    r.total = total;
    return r;
  endfunction

  initial begin
    foreach (edges[i]) edges[i] = '0;
    foreach (lens[i]) begin
      lens[i] = '0;
      links[i] = '0;
    end
  end

  assign pending_o = replies_q.size();
  assign errors_o = n_errors;

  always @(posedge clk_i) begin
    reply_t got, want, nxt;
    if (rst_ni && s_valid_i && s_ready_i) begin
      nxt = automaton_step(s_user_i, int'(s_data_i[4:0]), int'(s_data_i[15:5]));
      replies_q = {replies_q, nxt};
    end
    if (rst_ni && m_valid_i && m_ready_i) begin
      got.status   = m_data_i[1:0];
      got.node     = m_data_i[12:2];
      got.found    = m_data_i[13];
      got.len      = m_data_i[24:14];
      got.link     = m_data_i[35:25];
      got.has_link = m_data_i[36];
      got.cloned   = m_data_i[37];
      got.total    = m_data_i[57:38];
      if (replies_q.size() == 0) begin
        $display("%0t unexpected transaction: got %h", $time, got);
        n_errors++;
      end else begin
        want = replies_q.pop_front();
        if (got.status != want.status || got.node != want.node ||
            got.found != want.found || got.len != want.len ||
            got.link != want.link || got.has_link != want.has_link ||
            got.cloned != want.cloned || got.total != want.total ||
            m_data_i[63:58] != '0) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          n_errors++;
        end
      end
    end
  end
endmodule

FILE: dv/tb_suffix_automaton_builder_unit.sv
`timescale 1ns / 1ps
module tb_suffix_automaton_builder_unit;
  import sab_pkg::*;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             s_valid = 0;
  logic             s_ready;
  logic             s_user = 0;
  logic [IN_W-1:0]  s_data = '0;
  logic             m_valid;
  logic             m_ready = 0;
  logic [OUT_W-1:0] m_data;
  int               errors, pending;
  longint           cycles = 0;
  bit               hold_off = 0;
  int               stall_mode = 0;
  int               n_appends = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  suffix_automaton_builder_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tuser_i(s_user),
    .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data)
  );

  sab_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_user_i(s_user), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("[suffix_automaton_builder_unit] ERROR");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) m_ready <= 0;
    else case (stall_mode)
      0: m_ready <= 1;
      1: m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic send(logic act, logic [4:0] sym, logic [10:0] idx);
    s_valid <= 1;
    s_user <= act;
    s_data <= {idx, sym};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    if (act == ACT_APPEND) n_appends++;
  endtask

  task automatic pause(int n);
    s_valid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain;
    s_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_item(int alpha, int idx_hi);
    if ($urandom_range(0, 2) != 0)
      send(ACT_APPEND, 5'($urandom_range(0, alpha - 1)), 11'($urandom));
    else
      send(ACT_READ, 5'($urandom_range(0, 31)), 11'($urandom_range(0, idx_hi)));
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    send(ACT_READ, 5'd0, 11'd0);
    send(ACT_READ, 5'd31, 11'd2047);
    send(ACT_APPEND, 5'd26, 11'd0);
    send(ACT_APPEND, 5'd31, 11'h7ff);
    send(ACT_APPEND, 5'd0, 11'd0);
    send(ACT_APPEND, 5'd1, 11'd0);
    send(ACT_APPEND, 5'd1, 11'd0);
    send(ACT_APPEND, 5'd0, 11'd0);
    send(ACT_APPEND, 5'd1, 11'd0);
    send(ACT_APPEND, 5'd25, 11'd0);
    send(ACT_READ, 5'd1, 11'd0);
    send(ACT_READ, 5'd1, 11'd3);
    send(ACT_READ, 5'd30, 11'd4);
    send(ACT_READ, 5'd0, 11'd1);
    send(ACT_READ, 5'd0, 11'd1023);
    drain();
    // long receiver hold-off while sender keeps offering
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) random_item(3, 15);
    join
    drain();
    // random: small alphabets give deep suffix-link chains and clones
    for (int i = 0; i < 450; i++) begin
      if (i % 75 == 0) stall_mode = $urandom_range(0, 2);
      burst = $urandom_range(0, 9);
      if (burst == 0) pause($urandom_range(1, 20));
      random_item(i < 200 ? 2 : (i < 350 ? 4 : 26), 2047);
    end
    // fill the store, then hit refusals
    stall_mode = 0;
    while (n_appends < MAX_LEN + 4) send(ACT_APPEND, 5'($urandom_range(0, 2)), 11'd0);
    send(ACT_APPEND, 5'd0, 11'd0);
    send(ACT_READ, 5'd0, 11'd2047);
    send(ACT_READ, 5'd1, 11'd1);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[suffix_automaton_builder_unit] OK");
    end else begin
      $display("[suffix_automaton_builder_unit] ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/sab_pkg.sv
rtl/suffix_automaton_builder_unit.sv
dv/sab_checker.sv
dv/tb_suffix_automaton_builder_unit.sv
